FILE: rtl/stereo_fade_envelope_top_macros.svh
// Assertion helpers for the stereo fade envelope block.
`ifndef STEREO_FADE_ENVELOPE_TOP_MACROS_SVH
`define STEREO_FADE_ENVELOPE_TOP_MACROS_SVH

`ifndef SYNTH

// Check that the antecedent implies the consequent in the same cycle.
`define SFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfe assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define SFE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfe assertion failed");

`else

`define SFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/sfe_pkg.sv
package sfe_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 24;
   localparam int POS_W    = 32;
   localparam int TOTAL_W  = 31;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LENGTH    = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last_frame;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last_out;
   } rsp_type;

   // Command to the shared divide step unit
   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } div_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_SETUP,
      S_FI_LOAD,
      S_FI_DIV,
      S_FO_LOAD,
      S_FO_DIV,
      S_GAIN,
      S_GAIN_REG,
      S_MUL_L,
      S_MUL_R,
      S_DONE
   } state_type;

endpackage

FILE: rtl/stereo_fade_envelope_top.sv
// Linear fade-in / fade-out gain on signed 16-bit stereo frames. Each request
// is one frame; its clip position is start_position plus a frame counter that
// advances per frame and clears after a frame marked last. The gain is the
// product of a fade-in ramp and a fade-out ramp, each an unsigned fraction with
// GAIN_FRAC_BITS fraction bits clamped to 0..1, and both channels are scaled
// by it, truncating toward zero. The shared divider produces one quotient
// bit per cycle for each of the two ramps; the shared multiplier then forms
// the gain and both scaled samples. The block takes no new request until the
// current one is finished; a finished result waits in the output register
// while the next request is already being accepted. Registers must be written
// only while the block is idle; the block itself does not enforce this.
`include "stereo_fade_envelope_top_macros.svh"

module stereo_fade_envelope_top
   import sfe_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int QW    = GAIN_FRAC_BITS + 1;
   localparam int MW    = (QW > SAMPLE_W + 1) ? QW : SAMPLE_W + 1;
   localparam int CNT_W = $clog2(QW);
   localparam int PW    = POS_W + 2;
   localparam logic [QW-1:0]     UNITY_Q    = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
   localparam logic [2*MW-1:0]   UNITY_WIDE = {{(2*MW-QW){1'b0}}, UNITY_Q};
   localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(QW - 1);

   // Configuration registers
   logic [LEN_W-1:0]   fil_ff;
   logic [LEN_W-1:0]   fol_ff;
   logic [POS_W-1:0]   start_ff;
   logic [TOTAL_W-1:0] total_ff;

   // Control state
   state_type          state_ff;
   state_type          state_in;
   logic [POS_W-1:0]   offset_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;

   // Per-request datapath registers
   req_type            req_hold_ff;
   logic signed [PW-1:0] pos_ff;
   logic [LEN_W-1:0]   fi_x_ff;
   logic [LEN_W-1:0]   fo_x_ff;
   logic               fi_unity_ff;
   logic               fo_unity_ff;
   logic [QW-1:0]      fi_ff;
   logic [QW-1:0]      gain_ff;
   logic [SAMPLE_W-1:0] left_res_ff;
   rsp_type            rsp_ff;

   // Shared units
   div_cmd_type        div_cmd;
   logic [LEN_W-1:0]   div_dividend;
   logic [LEN_W-1:0]   div_divisor;
   logic [QW-1:0]      div_quo;
   logic [MW-1:0]      mul_a;
   logic [MW-1:0]      mul_b;
   logic [2*MW-1:0]    mul_prod;

   // Combinational helpers
   logic               req_fire;
   logic               done_fire;
   logic signed [PW-1:0] pos_in;
   logic signed [PW-1:0] rem_pos;
   logic               fi_active;
   logic               fo_active;
   logic [QW-1:0]      fo_sel;
   logic [2*MW-1:0]    gain_wide;
   logic [QW-1:0]      gain_in;
   logic [SAMPLE_W:0]  mag_l;
   logic [SAMPLE_W:0]  mag_r;
   logic [SAMPLE_W-1:0] scaled;
   logic [SAMPLE_W-1:0] scaled_l;
   logic [SAMPLE_W-1:0] scaled_r;

   sfe_div_unit #(
      .QUO_W(QW)
   ) u_div (
      .clock   (clock),
      .cmd     (div_cmd),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quo)
   );

   sfe_mul_unit #(
      .MUL_W(MW)
   ) u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .product(mul_prod)
   );

   assign req_fire  = req_valid && req_ready;
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Position and ramp windows
   always_comb begin
      pos_in    = $signed({{2{start_ff[POS_W-1]}}, start_ff})
                + $signed({2'b00, offset_ff});
      rem_pos   = $signed({3'b000, total_ff}) - pos_ff;
      fi_active = (fil_ff != '0) && (pos_ff < $signed({10'd0, fil_ff}));
      fo_active = (fol_ff != '0) && (rem_pos <= $signed({10'd0, fol_ff}));
   end

   // Gain from the fade product, clamped to unity
   always_comb begin
      fo_sel    = fo_unity_ff ? UNITY_Q : div_quo;
      gain_wide = mul_prod >> GAIN_FRAC_BITS;
      gain_in   = (gain_wide > UNITY_WIDE) ? UNITY_Q : gain_wide[QW-1:0];
   end

   // Sample magnitudes and sign-restored scaled results
   always_comb begin
      mag_l = req_hold_ff.left_sample[SAMPLE_W-1]
            ? (~{req_hold_ff.left_sample[SAMPLE_W-1], req_hold_ff.left_sample}
               + (SAMPLE_W+1)'(1))
            : {1'b0, req_hold_ff.left_sample};
      mag_r = req_hold_ff.right_sample[SAMPLE_W-1]
            ? (~{req_hold_ff.right_sample[SAMPLE_W-1], req_hold_ff.right_sample}
               + (SAMPLE_W+1)'(1))
            : {1'b0, req_hold_ff.right_sample};
      scaled   = mul_prod[GAIN_FRAC_BITS +: SAMPLE_W];
      scaled_l = req_hold_ff.left_sample[SAMPLE_W-1]
               ? (~scaled + SAMPLE_W'(1)) : scaled;
      scaled_r = req_hold_ff.right_sample[SAMPLE_W-1]
               ? (~scaled + SAMPLE_W'(1)) : scaled;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_POS;
         S_POS:      state_in = S_SETUP;
         S_SETUP:    state_in = S_FI_LOAD;
         S_FI_LOAD:  state_in = S_FI_DIV;
         S_FI_DIV:   if (cnt_ff == CNT_LAST) state_in = S_FO_LOAD;
         S_FO_LOAD:  state_in = S_FO_DIV;
         S_FO_DIV:   if (cnt_ff == CNT_LAST) state_in = S_GAIN;
         S_GAIN:     state_in = S_GAIN_REG;
         S_GAIN_REG: state_in = S_MUL_L;
         S_MUL_L:    state_in = S_MUL_R;
         S_MUL_R:    state_in = S_DONE;
         S_DONE:     if (done_fire) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, divider commands, multiplier operands
   always_comb begin
      req_ready    = 1'b0;
      div_cmd      = '0;
      div_dividend = fi_x_ff;
      div_divisor  = fil_ff;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff) inside
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_FI_LOAD: begin
            div_cmd.load = 1'b1;
         end
         S_FI_DIV: begin
            div_cmd.step  = 1'b1;
            div_cmd.shift = (cnt_ff != '0);
         end
         S_FO_LOAD: begin
            div_cmd.load = 1'b1;
            div_dividend = fo_x_ff;
            div_divisor  = fol_ff;
         end
         S_FO_DIV: begin
            div_cmd.step  = 1'b1;
            div_cmd.shift = (cnt_ff != '0);
            div_divisor   = fol_ff;
         end
         S_GAIN: begin
            mul_a = MW'(fi_ff);
            mul_b = MW'(fo_sel);
         end
         S_MUL_L: begin
            mul_a = MW'(mag_l);
            mul_b = MW'(gain_ff);
         end
         S_MUL_R, S_DONE: begin
            mul_a = MW'(mag_r);
            mul_b = MW'(gain_ff);
         end
         default: begin
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fil_ff   <= '0;
         fol_ff   <= '0;
         start_ff <= '0;
         total_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FADE_IN_LENGTH:  fil_ff   <= csr_wdata[LEN_W-1:0];
            CSR_FADE_OUT_LENGTH: fol_ff   <= csr_wdata[LEN_W-1:0];
            CSR_START_POSITION:  start_ff <= csr_wdata[POS_W-1:0];
            CSR_TOTAL_LENGTH:    total_ff <= csr_wdata[TOTAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state: sequencer, frame counter, step counter, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         offset_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_POS) begin
            offset_ff <= req_hold_ff.last_frame ? '0 : offset_ff + POS_W'(1);
         end
         if (state_ff == S_FI_LOAD || state_ff == S_FO_LOAD) begin
            cnt_ff <= '0;
         end else if (state_ff == S_FI_DIV || state_ff == S_FO_DIV) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_hold_ff <= req_data;
      end
      if (state_ff == S_POS) begin
         pos_ff <= pos_in;
      end
      if (state_ff == S_SETUP) begin
         fi_unity_ff <= !fi_active;
         fo_unity_ff <= !fo_active;
         fi_x_ff     <= (pos_ff > $signed(PW'(0))) ? pos_ff[LEN_W-1:0] : '0;
         fo_x_ff     <= (rem_pos > $signed(PW'(0))) ? rem_pos[LEN_W-1:0] : '0;
      end
      if (state_ff == S_FO_LOAD) begin
         fi_ff <= fi_unity_ff ? UNITY_Q : div_quo;
      end
      if (state_ff == S_GAIN_REG) begin
         gain_ff <= gain_in;
      end
      if (state_ff == S_MUL_R) begin
         left_res_ff <= scaled_l;
      end
      if (done_fire) begin
         rsp_ff.left_out  <= left_res_ff;
         rsp_ff.right_out <= scaled_r;
         rsp_ff.last_out  <= req_hold_ff.last_frame;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted request starts the position step
   `SFE_ASSERT_NXT(a_accept_starts, clock, reset, req_fire, state_ff == S_POS)

   // The frame counter clears after a frame marked last
   `SFE_ASSERT_NXT(a_last_clears_offset, clock, reset,
      (state_ff == S_POS) && req_hold_ff.last_frame, offset_ff == '0)

   // A finished result waits while the output register is still occupied
   `SFE_ASSERT_NXT(a_done_holds, clock, reset,
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready, state_ff == S_DONE)

   // The gain never exceeds unity
   `SFE_ASSERT_IMP(a_gain_unity, clock, reset, state_ff == S_MUL_L, gain_ff <= UNITY_Q)

endmodule

FILE: rtl/sfe_div_unit.sv
module sfe_div_unit
   import sfe_pkg::*;
#(
   parameter int QUO_W = 17
) (
   input  logic              clock,
   input  div_cmd_type       cmd,
   input  logic [LEN_W-1:0]  dividend,
   input  logic [LEN_W-1:0]  divisor,
   output logic [QUO_W-1:0]  quotient
);

   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [LEN_W:0]   cand;
   logic [LEN_W:0]   dz;
   logic [LEN_W:0]   diff;
   logic             ge;

   // Load the dividend, or one restoring step: shift in a zero when shift is set, compare, subtract if it fits
   always_comb begin
      cand = cmd.shift ? {rem_ff, 1'b0} : {1'b0, rem_ff};
      dz   = {1'b0, divisor};
      ge   = (cand >= dz);
      diff = cand - dz;
      if (cmd.load) begin
         rem_in = dividend;
         quo_in = '0;
      end else if (cmd.step) begin
         rem_in = ge ? diff[LEN_W-1:0] : cand[LEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end else begin
         rem_in = rem_ff;
         quo_in = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: rtl/sfe_mul_unit.sv
module sfe_mul_unit
   import sfe_pkg::*;
#(
   parameter int MUL_W = 17
) (
   input  logic                 clock,
   input  logic [MUL_W-1:0]     op_a,
   input  logic [MUL_W-1:0]     op_b,
   output logic [2*MUL_W-1:0]   product
);

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   // Unsigned multiply, registered
   assign prod_in = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

FILE: tb/stereo_fade_envelope_top_tb.sv
module stereo_fade_envelope_top_tb;
   import sfe_pkg::*;

   localparam int GAIN_FRAC_BITS = 16;
   localparam longint UNITY = longint'(1) << GAIN_FRAC_BITS;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_FRAMES = 1925;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FADE_IN_LENGTH;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Envelope settings and frame counter as the block should hold them
   logic [LEN_W-1:0]          env_fade_in;
   logic [LEN_W-1:0]          env_fade_out;
   logic signed [POS_W-1:0]   env_start;
   logic [TOTAL_W-1:0]        env_total;
   logic [31:0]               env_frame_count;

   rsp_type expected_frames[$];
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      rsp_hold = 0;
   int      rsp_stall;
   bit      no_idle = 1'b0;

   stereo_fade_envelope_top #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Scale one sample by the gain, truncating toward zero
   function automatic logic [SAMPLE_W-1:0] scale_channel(input logic signed [SAMPLE_W-1:0] sample,
                                                         input longint gain);
      longint value;
      longint mag;
      longint prod;
      value = sample;
      mag = (value < 0) ? -value : value;
      prod = (mag * gain) >>> GAIN_FRAC_BITS;
      if (value < 0) begin
         prod = -prod;
      end
      return prod[SAMPLE_W-1:0];
   endfunction

   // Apply the fade-in and fade-out ramps at the current clip position
   function automatic rsp_type faded_frame(input req_type frame);
      longint  pos;
      longint  ramp_in;
      longint  ramp_out;
      longint  remain;
      longint  gain;
      rsp_type result;
      pos = longint'(env_start) + longint'({32'd0, env_frame_count});
      ramp_in = UNITY;
      ramp_out = UNITY;
      if (env_fade_in != 0 && pos < longint'({40'd0, env_fade_in})) begin
         ramp_in = (pos <= 0) ? 0 : (pos * UNITY) / longint'({40'd0, env_fade_in});
      end
      if (env_fade_out != 0 &&
          pos >= longint'({33'd0, env_total}) - longint'({40'd0, env_fade_out})) begin
         remain = longint'({33'd0, env_total}) - pos;
         ramp_out = (remain <= 0) ? 0 : (remain * UNITY) / longint'({40'd0, env_fade_out});
      end
      gain = (ramp_in * ramp_out) >>> GAIN_FRAC_BITS;
      if (gain > UNITY) begin
         gain = UNITY;
      end
      result.left_out = scale_channel(frame.left_sample, gain);
      result.right_out = scale_channel(frame.right_sample, gain);
      result.last_out = frame.last_frame;
      return result;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(7, 0))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Present one request after a random gap, then record its expected result
   task automatic send_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                             input logic last);
      int      gap;
      req_type frame;
      frame.left_sample = left;
      frame.right_sample = right;
      frame.last_frame = last;
      gap = no_idle ? 0 : $urandom_range(9, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         // count the gap only while the block would take a request
         while (gap > 0) begin
            @(posedge clock);
            if (req_ready) begin
               gap--;
            end
         end
      end
      req_valid <= 1'b1;
      req_data <= frame;
      do @(posedge clock); while (!req_ready);
      expected_frames.push_back(faded_frame(frame));
      env_frame_count = last ? 32'd0 : env_frame_count + 32'd1;
   endtask

   // Drop valid and wait until every result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_W-1:0] in_word, input logic [CSR_W-1:0] out_word,
                                  input logic [CSR_W-1:0] start_word,
                                  input logic [CSR_W-1:0] total_word);
      env_fade_in = in_word[LEN_W-1:0];
      env_fade_out = out_word[LEN_W-1:0];
      env_start = start_word;
      env_total = total_word[TOTAL_W-1:0];
      csr_write_en <= 1'b1;
      csr_index <= CSR_FADE_IN_LENGTH;
      csr_wdata <= in_word;
      @(posedge clock);
      csr_index <= CSR_FADE_OUT_LENGTH;
      csr_wdata <= out_word;
      @(posedge clock);
      csr_index <= CSR_START_POSITION;
      csr_wdata <= start_word;
      @(posedge clock);
      csr_index <= CSR_TOTAL_LENGTH;
      csr_wdata <= total_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Reset settings: both lengths zero, samples must pass unchanged
   task automatic test_passthrough();
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h0000, 16'hFFFF, 1'b0);
      send_frame(16'hFFFF, 16'h0001, 1'b1);
      send_frame(16'h5555, 16'hAAAA, 1'b0);
      send_frame(16'hAAAA, 16'h5555, 1'b1);
      wait_idle();
   endtask

   // Fade-in from a negative position through the ramp into full gain
   task automatic test_fade_in_ramp();
      write_registers(32'd5, 32'd0, -32'sd1, 32'd0);
      for (int i = 0; i < 8; i++) begin
         send_frame(16'h7FFF, 16'h8000, i == 7);
      end
      wait_idle();
   endtask

   // Fade-out ramp down to the total length and past it
   task automatic test_fade_out_ramp();
      write_registers(32'd0, 32'd3, 32'd0, 32'd5);
      for (int i = 0; i < 7; i++) begin
         send_frame(16'h8000, 16'h7FFF, i == 6);
      end
      wait_idle();
   endtask

   // Register values at the edges of their ranges, upper bits set
   task automatic test_extreme_settings();
      write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b1);
      wait_idle();
      write_registers(32'hFF00_0001, 32'hFF00_0001, 32'h7FFF_FFFF, 32'h8000_0000);
      send_frame(16'h7FFF, 16'hFFFF, 1'b0);
      send_frame(16'h8000, 16'h0001, 1'b1);
      wait_idle();
   endtask

   // Buffers of random frames under random envelope settings
   task automatic test_random_buffers();
      int               sent;
      int               frames;
      logic [CSR_W-1:0] in_word;
      logic [CSR_W-1:0] out_word;
      logic [CSR_W-1:0] start_word;
      logic [CSR_W-1:0] total_word;
      sent = 0;
      while (sent < RANDOM_FRAMES) begin
         in_word = $urandom;
         out_word = $urandom;
         total_word = $urandom;
         case ($urandom_range(7, 0))
            0: in_word[LEN_W-1:0] = '0;
            1: in_word[LEN_W-1:0] = '1;
            2: ;
            default: in_word[LEN_W-1:0] = LEN_W'($urandom_range(40, 1));
         endcase
         case ($urandom_range(7, 0))
            0: out_word[LEN_W-1:0] = '0;
            1: out_word[LEN_W-1:0] = '1;
            2: ;
            default: out_word[LEN_W-1:0] = LEN_W'($urandom_range(40, 1));
         endcase
         case ($urandom_range(7, 0))
            0: total_word[TOTAL_W-1:0] = '0;
            1: total_word[TOTAL_W-1:0] = '1;
            2: ;
            default: total_word[TOTAL_W-1:0] = TOTAL_W'($urandom_range(120, 0));
         endcase
         // place the buffer near a ramp most of the time
         case ($urandom_range(9, 0))
            0: start_word = 32'h8000_0000;
            1: start_word = 32'h7FFF_FFFF;
            2: start_word = $urandom;
            3, 4: start_word = {8'd0, in_word[LEN_W-1:0]} - $urandom_range(30, 0);
            5, 6: start_word = {1'b0, total_word[TOTAL_W-1:0]} - {8'd0, out_word[LEN_W-1:0]}
                               - $urandom_range(10, 0);
            default: start_word = $urandom_range(80, 0) - 20;
         endcase
         write_registers(in_word, out_word, start_word, total_word);
         no_idle = ($urandom_range(3, 0) == 0);
         frames = $urandom_range(120, 10);
         for (int i = 0; i < frames; i++) begin
            send_frame(random_sample(), random_sample(),
                       ($urandom_range(15, 0) == 0) ||
                       (i == frames - 1 && $urandom_range(1, 0) == 0));
         end
         sent += frames;
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   // Compare one result with the oldest expectation
   task automatic check_frame(input rsp_type got);
      rsp_type want;
      if (expected_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result L=%0d R=%0d last=%0b",
                     got.left_out, got.right_out, got.last_out);
         end
      end else begin
         want = expected_frames.pop_front();
         if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
             got.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                        want.left_out, want.right_out, want.last_out,
                        got.left_out, got.right_out, got.last_out);
            end
         end
      end
   endtask

   // Take results, stalling each for a random count of cycles while it waits
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         check_frame(rsp_data);
         rsp_stall = no_idle ? 0 : $urandom_range(9, 0);
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= rsp_stall;
         end
      end else if (rsp_valid && !rsp_ready) begin
         if (rsp_hold <= 1) begin
            rsp_ready <= 1'b1;
         end
         rsp_hold <= rsp_hold - 1;
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** stereo_fade_envelope_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      env_fade_in = '0;
      env_fade_out = '0;
      env_start = '0;
      env_total = '0;
      env_frame_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_fade_in_ramp();
      test_fade_out_ramp();
      test_extreme_settings();
      test_random_buffers();
      wait_idle();
      repeat (50) @(posedge clock);
      if (expected_frames.size() != 0) begin
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("** stereo_fade_envelope_top: PASSED **");
      end else begin
         $display("** stereo_fade_envelope_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sfe_pkg.sv
rtl/sfe_div_unit.sv
rtl/sfe_mul_unit.sv
rtl/stereo_fade_envelope_top.sv
tb/stereo_fade_envelope_top_tb.sv
